// File: rtl/ordered_list_engine_unit_assert.svh
// Assertion macros used by the ordered list engine port checker.
`ifndef ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define OLE_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("ordered list engine: check failed");

// Next-cycle implication, disabled while reset is low.
`define OLE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("ordered list engine: check failed");

`endif

// File: rtl/olist_pkg.sv
// Types and codes shared by the ordered list engine modules.
package olist_pkg;

  localparam int unsigned ValueW = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_DELETE     = 2'd2,
    OP_READ_OUT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_MATCH,
    S_DEL,
    S_READ
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic    in_ready;
    logic    push;
    logic    match;
    logic    del;
    logic    read_step;
    logic    emit;
    status_t emit_status;
    logic    emit_last;
    logic    emit_cell;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_valid;
    op_t  in_op;
    logic slot_free;
    logic is_empty;
    logic is_full;
    logic found;
    logic read_last;
  } sts_t;

endpackage

// File: rtl/olist_if.sv
// Valid/ready channel interfaces for operation transactions and result transactions.
interface olist_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic signed [olist_pkg::ValueW-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface olist_out_if;
  logic        valid;
  logic        ready;
  logic signed [olist_pkg::ValueW-1:0] item_value;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output item_value, output status, output last, input ready);
  modport sink   (input valid, input item_value, input status, input last, output ready);
endinterface

// File: rtl/olist_dp.sv
// Datapath: cell row, entry count, match vector and the result register.
module olist_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  olist_in_if.sink           in_chan,
  olist_out_if.source        out_chan,
  input  olist_pkg::cmd_t    cmd,
  output olist_pkg::sts_t    sts
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned VW = olist_pkg::ValueW;

  olist_pkg::op_t      op_r;
  logic signed [VW-1:0] val_r;
  logic signed [VW-1:0] cells_r   [CAPACITY];
  logic signed [VW-1:0] cells_nxt [CAPACITY];
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [CAPACITY-1:0] match_r, match_nxt;
  logic [CAPACITY-1:0] after_hit;
  logic                out_valid_r;
  logic signed [VW-1:0] out_item_r;
  olist_pkg::status_t  out_status_r;
  logic                out_last_r;
  logic                load;
  logic                is_empty, is_full, found, read_last;
  logic                push_ok, del_ok;

  assign load      = cmd.in_ready && in_chan.valid;
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CW'(CAPACITY));
  assign found     = |match_r;
  assign read_last = ((CW'(idx_r) + CW'(1)) == count_r);
  assign push_ok   = cmd.push && !is_full;
  assign del_ok    = cmd.del && found;

  assign in_chan.ready = cmd.in_ready;

  assign sts.in_valid  = in_chan.valid;
  assign sts.in_op     = olist_pkg::op_t'(in_chan.operation);
  assign sts.slot_free = !out_valid_r || out_chan.ready;
  assign sts.is_empty  = is_empty;
  assign sts.is_full   = is_full;
  assign sts.found     = found;
  assign sts.read_last = read_last;

  // Positions at or beyond the first match.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      after_hit[i] = |(match_r << (CAPACITY - 1 - i));
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = (cells_r[i] == val_r) && (CW'(i) < count_r);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
      if (push_ok && op_r == olist_pkg::OP_PUSH_FRONT) begin
        cells_nxt[i] = (i == 0) ? val_r : cells_r[(i == 0) ? 0 : i - 1];
      end else if (push_ok) begin
        if (CW'(i) == count_r) cells_nxt[i] = val_r;
      end else if (del_ok) begin
        if (after_hit[i] && i < CAPACITY - 1)
          cells_nxt[i] = cells_r[(i < CAPACITY - 1) ? i + 1 : i];
      end else if (cmd.read_step) begin
        // rotate the live entries by one so the next one sits at the head
        if ((CW'(i) + CW'(1)) == count_r) cells_nxt[i] = cells_r[0];
        else if (i < CAPACITY - 1) cells_nxt[i] = cells_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push_ok)     count_nxt = count_r + CW'(1);
    else if (del_ok) count_nxt = count_r - CW'(1);
  end

  always_comb begin
    idx_nxt = idx_r;
    if (load)               idx_nxt = '0;
    else if (cmd.read_step) idx_nxt = idx_r + IW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (cmd.emit)          out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r  <= olist_pkg::op_t'(in_chan.operation);
      val_r <= in_chan.value;
    end
    if (cmd.match) match_r <= match_nxt;
    for (int i = 0; i < CAPACITY; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
    if (cmd.emit) begin
      out_item_r   <= cmd.emit_cell ? cells_r[0] : '0;
      out_status_r <= cmd.emit_status;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.item_value = out_item_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.last       = out_last_r;

endmodule

// File: rtl/olist_ctrl.sv
// Controller: sequences each operation and issues result transactions.
module olist_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  olist_pkg::sts_t sts,
  output olist_pkg::cmd_t cmd
);

  olist_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= olist_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      olist_pkg::S_IDLE: begin
        if (sts.in_valid) begin
          unique case (sts.in_op)
            olist_pkg::OP_PUSH_FRONT,
            olist_pkg::OP_PUSH_BACK: state_nxt = olist_pkg::S_PUSH;
            olist_pkg::OP_DELETE:    state_nxt = olist_pkg::S_MATCH;
            olist_pkg::OP_READ_OUT:  state_nxt = olist_pkg::S_READ;
            default:                 state_nxt = olist_pkg::S_IDLE;
          endcase
        end
      end
      olist_pkg::S_PUSH:  if (sts.slot_free) state_nxt = olist_pkg::S_IDLE;
      olist_pkg::S_MATCH: state_nxt = olist_pkg::S_DEL;
      olist_pkg::S_DEL:   if (sts.slot_free) state_nxt = olist_pkg::S_IDLE;
      olist_pkg::S_READ: begin
        if (sts.slot_free && (sts.is_empty || sts.read_last)) state_nxt = olist_pkg::S_IDLE;
      end
      default: state_nxt = olist_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.emit_status = olist_pkg::ST_OK;
    unique case (state_r)
      olist_pkg::S_IDLE: cmd.in_ready = 1'b1;
      olist_pkg::S_PUSH: begin
        if (sts.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.push        = !sts.is_full;
          cmd.emit_status = sts.is_full ? olist_pkg::ST_FULL : olist_pkg::ST_OK;
        end
      end
      olist_pkg::S_MATCH: cmd.match = 1'b1;
      olist_pkg::S_DEL: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          priority if (sts.is_empty) cmd.emit_status = olist_pkg::ST_EMPTY;
          else if (!sts.found)       cmd.emit_status = olist_pkg::ST_NOT_FOUND;
          else begin
            cmd.del         = 1'b1;
            cmd.emit_status = olist_pkg::ST_OK;
          end
        end
      end
      olist_pkg::S_READ: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.is_empty) begin
            cmd.emit_status = olist_pkg::ST_EMPTY;
            cmd.emit_last   = 1'b1;
          end else begin
            cmd.emit_cell = 1'b1;
            cmd.read_step = 1'b1;
            cmd.emit_last = sts.read_last;
          end
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/ordered_list_engine_unit.sv
// Ordered list engine top level: a bounded deque of signed 32-bit values with
// push front, push back, delete of the first match and read out. One operation
// transaction is taken at a time; in_chan.ready is high only while the engine is
// idle. A push passes through S_PUSH back to idle. A delete passes through S_MATCH,
// which compares every cell in parallel and registers the match vector, and then
// S_DEL, which closes the gap. A read out issues one entry per cycle while the
// result channel does not stall, through the single result register, as the live
// entries rotate through the head cell; an empty list gives a single empty result.
// Entries live in a row of CAPACITY registers that need no clearing; the entry
// count resets to zero.
module ordered_list_engine_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  olist_in_if.sink     in_chan,
  olist_out_if.source  out_chan
);

  olist_pkg::cmd_t cmd;
  olist_pkg::sts_t sts;

  // sequencing of push, delete and read out
  olist_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // cells, count, match vector and result register
  olist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// File: rtl/olist_checker.sv
// Port-level checker for the ordered list engine, bound to the top level.
`include "ordered_list_engine_unit_assert.svh"

module olist_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_item_value,
  input logic [1:0]  out_status,
  input logic        out_last
);

  logic        out_stall;
  logic        out_err;
  logic [34:0] out_payload;

  assign out_stall   = out_valid && !out_ready;
  assign out_err     = out_valid && (out_status != olist_pkg::ST_OK);
  assign out_payload = {out_item_value, out_status, out_last};

  // stalled result holds
  `OLE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_payload))

  // one operation at a time
  `OLE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // error results close the transaction group
  `OLE_ASSERT_NOW(a_err_last, clk, rst_n, out_err, out_last)

  // error results carry no entry
  `OLE_ASSERT_NOW(a_err_zero, clk, rst_n, out_err, out_item_value == 32'd0)

endmodule

bind ordered_list_engine_unit olist_port_checker u_olist_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_item_value (out_chan.item_value),
  .out_status     (out_chan.status),
  .out_last       (out_chan.last)
);

// File: bench/olist_checker.sv
// Checker for the ordered list engine: predicts results per operation and compares.
module olist_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk,
  input  logic rst_n,
  olist_in_if  op_mon,
  olist_out_if res_mon,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   peak_depth,
  output int   full_hits
);
  import olist_pkg::*;

  localparam int MaxPrints = 50;

  typedef struct {
    logic signed [ValueW-1:0] item_value;
    status_t                  status;
    logic                     last;
  } result_t;

  result_t                  expected_q[$];
  logic signed [ValueW-1:0] list_q[$];

  function automatic void queue_result(logic signed [ValueW-1:0] item, status_t st, logic fin);
    result_t r;
    r.item_value = item;
    r.status     = st;
    r.last       = fin;
    expected_q.push_back(r);
  endfunction

  // Applies one operation transaction to the shadow list and queues its results.
  function automatic void apply_op(op_t op, logic signed [ValueW-1:0] val);
    int hit;
    hit = -1;
    case (op)
      OP_READ_OUT: begin
        if (list_q.size() == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          foreach (list_q[i]) queue_result(list_q[i], ST_OK, i == list_q.size() - 1);
        end
      end
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (list_q.size() >= CAPACITY) begin
          queue_result('0, ST_FULL, 1'b1);
          full_hits++;
        end else begin
          if (op == OP_PUSH_FRONT) list_q.push_front(val);
          else list_q.push_back(val);
          queue_result('0, ST_OK, 1'b1);
        end
      end
      default: begin
        if (list_q.size() == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          foreach (list_q[i]) if (hit < 0 && list_q[i] == val) hit = i;
          if (hit < 0) begin
            queue_result('0, ST_NOT_FOUND, 1'b1);
          end else begin
            list_q.delete(hit);
            queue_result('0, ST_OK, 1'b1);
          end
        end
      end
    endcase
    if (list_q.size() > peak_depth) peak_depth = list_q.size();
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= MaxPrints)
      $display("result transaction %0d: %s expected %0h got %0h", checked, what, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (op_mon.valid === 1'b1 && op_mon.ready === 1'b1)
        apply_op(op_t'(op_mon.operation), op_mon.value);
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) begin
        checked++;
        if (expected_q.size() == 0) begin
          report("unexpected transaction, item_value", '0, res_mon.item_value);
        end else begin
          want = expected_q.pop_front();
          if (res_mon.item_value !== want.item_value)
            report("item_value", want.item_value, res_mon.item_value);
          if (res_mon.status !== want.status)
            report("status", want.status, res_mon.status);
          if (res_mon.last !== want.last)
            report("last", want.last, res_mon.last);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: bench/tb_ordered_list_engine_unit.sv
// Testbench top for the ordered list engine: stimulus, handshake pacing and verdict.
module tb_ordered_list_engine_unit;
  import olist_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam int          Blocks   = 8;
  localparam int          BlockLen = 36;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } mix_t;

  logic clk;
  logic rst_n;

  olist_in_if  op_bus ();
  olist_out_if res_bus ();

  int fail_count;
  int pending;
  int checked;
  int peak_depth;
  int full_hits;
  int sent[4];
  bit quiet;   // no sender gaps during this block

  ordered_list_engine_unit #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (op_bus),
    .out_chan (res_bus)
  );

  olist_checker #(
    .CAPACITY (CAPACITY)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_mon     (op_bus),
    .res_mon    (res_bus),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .peak_depth (peak_depth),
    .full_hits  (full_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length before a transaction: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Small pool so deletes often find a match; extremes and full-width
  // random values keep every bit of the value field moving.
  function automatic logic signed [ValueW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $signed($urandom_range(0, 7)) - 3;
    if (r < 80) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic op_t pick_op(mix_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  begin
        if (r < 80) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if (r < 90) return OP_DELETE;
        return OP_READ_OUT;
      end
      MODE_DRAIN: begin
        if (r < 70) return OP_DELETE;
        if (r < 85) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        return OP_READ_OUT;
      end
      default: begin
        if (r < 30) return OP_PUSH_FRONT;
        if (r < 60) return OP_PUSH_BACK;
        if (r < 85) return OP_DELETE;
        return OP_READ_OUT;
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction
  // is accepted. valid stays high across back-to-back transactions.
  task automatic send(op_t op, logic signed [ValueW-1:0] val);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      op_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op_bus.valid     <= 1'b1;
    op_bus.operation <= op;
    op_bus.value     <= val;
    do @(posedge clk); while (op_bus.ready !== 1'b1);
    sent[op]++;
    @(negedge clk);
  endtask

  // Result side: runs of ready broken by stalls, occasionally long ones.
  initial begin
    int run;
    int stall;
    res_bus.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 6);
      res_bus.ready <= 1'b1;
      repeat (run) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Stimulus: directed corner cases first, then random blocks that take turns
  // draining, mixing and filling the list.
  initial begin
    mix_t mode;
    op_bus.valid     = 1'b0;
    op_bus.operation = OP_PUSH_FRONT;
    op_bus.value     = '0;
    rst_n            = 1'b0;
    quiet            = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Empty list: read out and delete both report empty.
    send(OP_READ_OUT, 32'sh1234_5678);
    send(OP_DELETE, '0);
    // Field extremes at both ends, plus a duplicate value.
    send(OP_PUSH_FRONT, 32'sh7fff_ffff);
    send(OP_PUSH_BACK, 32'sh8000_0000);
    send(OP_PUSH_FRONT, '0);
    send(OP_PUSH_BACK, '0);
    send(OP_READ_OUT, '1);
    // Delete hits the first of two equal entries, then a miss.
    send(OP_DELETE, '0);
    send(OP_DELETE, 32'sd77);
    // Fill to capacity with alternating ends and walking bit patterns.
    for (int k = 0; k < 13; k++) begin
      if (k % 2 == 0) send(OP_PUSH_FRONT, 32'sh1 << (2 * k + 1));
      else send(OP_PUSH_BACK, -(32'sh1 << k));
    end
    // Full list rejects pushes at both ends; read out emits every entry.
    send(OP_PUSH_FRONT, 32'sh5555_5555);
    send(OP_PUSH_BACK, 32'shaaaa_aaaa);
    send(OP_READ_OUT, '0);

    for (int blk = 0; blk < Blocks; blk++) begin
      mode  = mix_t'((blk + 1) % 3);
      quiet = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < BlockLen; n++) send(pick_op(mode), pick_value());
    end
    op_bus.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d operations: %0d push front, %0d push back, %0d delete, %0d read out.",
             sent[OP_PUSH_FRONT] + sent[OP_PUSH_BACK] + sent[OP_DELETE] + sent[OP_READ_OUT],
             sent[OP_PUSH_FRONT], sent[OP_PUSH_BACK], sent[OP_DELETE], sent[OP_READ_OUT]);
    $display("Checked %0d results; depth peaked at %0d of %0d, %0d pushes hit a full list.",
             checked, peak_depth, CAPACITY, full_hits);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with every stall at its longest.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
